[hdl/uubb_pkg.sv]
// ----------------------------------------------------------------------------
// uubb_pkg
// Shared command and result codes plus controller/datapath interface types.
// ----------------------------------------------------------------------------
package uubb_pkg;

    localparam logic [2:0] CMD_UART_BYTE = 3'd0;
    localparam logic [2:0] CMD_UART_IDLE = 3'd1;
    localparam logic [2:0] CMD_IN_DONE   = 3'd2;
    localparam logic [2:0] CMD_OUT_BEGIN = 3'd3;
    localparam logic [2:0] CMD_OUT_BYTE  = 3'd4;
    localparam logic [2:0] CMD_OUT_END   = 3'd5;
    localparam logic [2:0] CMD_TX_READY  = 3'd6;

    localparam logic [2:0] KIND_IN_BYTE  = 3'd0;
    localparam logic [2:0] KIND_ZLP      = 3'd1;
    localparam logic [2:0] KIND_NAK_SET  = 3'd2;
    localparam logic [2:0] KIND_NAK_CLR  = 3'd3;
    localparam logic [2:0] KIND_TX_BYTE  = 3'd4;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item
        logic rx_put;    // write byte into receive ring
        logic rx_clear;  // empty receive ring
        logic rx_snap;   // latch receive level left after the packet
        logic rx_rd;     // issue read of oldest receive byte
        logic rx_pop;    // remove oldest receive byte
        logic tx_put;    // write byte into transmit ring
        logic tx_rd;     // issue read of oldest transmit byte
        logic tx_pop;    // remove oldest transmit byte
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] command;
        logic       configured;
        logic       ep_free;
        logic       rx_full_pkt;  // receive count >= packet size
        logic       rx_empty;
        logic       tx_empty;
        logic       tx_over_nak;  // transmit count above nak-set threshold
        logic       tx_under_clr; // transmit count at or below nak-clear threshold
        logic       tx_one;       // transmit count equals one
    } t_dp_sts;

endpackage

[hdl/uubb_datapath.sv]
// ----------------------------------------------------------------------------
// uubb_datapath
// Receive and transmit byte rings with their heads, counts and item register.
// ----------------------------------------------------------------------------
module uubb_datapath
    import uubb_pkg::*;
#(
    parameter int RING_DEPTH   = 128,
    parameter int PACKET_BYTES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [2:0]                    i_command,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_bus_configured,
    input  logic                          i_endpoint_free,
    input  t_dp_cmd                       i_cmd,
    output t_dp_sts                       o_sts,
    output logic [7:0]                    o_rx_q,
    output logic [7:0]                    o_tx_q,
    output logic [$clog2(RING_DEPTH+1)-1:0] o_rx_count,
    output logic [$clog2(RING_DEPTH+1)-1:0] o_rx_final
);
    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(RING_DEPTH);
    localparam logic [CW-1:0] PKT_C    = CW'(PACKET_BYTES);
    localparam logic [CW-1:0] NAK_SET  = CW'(RING_DEPTH - 2 * PACKET_BYTES);
    localparam logic [CW-1:0] NAK_CLR  = CW'(RING_DEPTH - PACKET_BYTES);

    logic [7:0]    r_rx_mem [RING_DEPTH];
    logic [7:0]    r_tx_mem [RING_DEPTH];
    logic [AW-1:0] r_rx_head, r_tx_head;
    logic [CW-1:0] r_rx_count, r_tx_count;
    logic [CW-1:0] r_rx_final;
    logic [2:0]    r_command;
    logic [7:0]    r_byte;
    logic          r_conf, r_free;
    logic [7:0]    r_rx_q, r_tx_q;
    logic [AW-1:0] rx_tail, tx_tail;

    // oldest entry sits count places behind the head, modulo the ring depth
    assign rx_tail = (CW'(r_rx_head) >= r_rx_count) ?
                     AW'(CW'(r_rx_head) - r_rx_count) :
                     AW'(CW'(r_rx_head) + DEPTH_C - r_rx_count);
    assign tx_tail = (CW'(r_tx_head) >= r_tx_count) ?
                     AW'(CW'(r_tx_head) - r_tx_count) :
                     AW'(CW'(r_tx_head) + DEPTH_C - r_tx_count);

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] h);
        return (32'(h) + 1 >= RING_DEPTH) ? '0 : h + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_command <= i_command;
            r_byte    <= i_data_byte;
            r_conf    <= i_bus_configured;
            r_free    <= i_endpoint_free;
        end
        if (i_cmd.rx_put) r_rx_mem[r_rx_head] <= r_byte;
        if (i_cmd.tx_put) r_tx_mem[r_tx_head] <= r_byte;
        if (i_cmd.rx_rd)  r_rx_q <= r_rx_mem[rx_tail];
        if (i_cmd.tx_rd)  r_tx_q <= r_tx_mem[tx_tail];
        if (i_cmd.rx_snap)
            r_rx_final <= (r_rx_count >= PKT_C) ? r_rx_count - PKT_C : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head  <= '0;
            r_rx_count <= '0;
            r_tx_head  <= '0;
            r_tx_count <= '0;
        end else begin
            if (i_cmd.rx_clear) begin
                r_rx_head  <= '0;
                r_rx_count <= '0;
            end else if (i_cmd.rx_put) begin
                r_rx_head <= f_inc(r_rx_head);
                if (r_rx_count < DEPTH_C) r_rx_count <= r_rx_count + 1'b1;
            end else if (i_cmd.rx_pop && r_rx_count != '0) begin
                r_rx_count <= r_rx_count - 1'b1;
            end
            if (i_cmd.tx_put) begin
                r_tx_head <= f_inc(r_tx_head);
                if (r_tx_count < DEPTH_C) r_tx_count <= r_tx_count + 1'b1;
            end else if (i_cmd.tx_pop && r_tx_count != '0) begin
                r_tx_count <= r_tx_count - 1'b1;
            end
        end
    end

    always_comb begin
        o_sts.command      = r_command;
        o_sts.configured   = r_conf;
        o_sts.ep_free      = r_free;
        o_sts.rx_full_pkt  = r_rx_count >= PKT_C;
        o_sts.rx_empty     = r_rx_count == '0;
        o_sts.tx_empty     = r_tx_count == '0;
        o_sts.tx_over_nak  = r_tx_count > NAK_SET;
        o_sts.tx_under_clr = r_tx_count <= NAK_CLR;
        o_sts.tx_one       = r_tx_count == CW'(1);
    end

    assign o_rx_q     = r_rx_q;
    assign o_tx_q     = r_tx_q;
    assign o_rx_count = r_rx_count;
    assign o_rx_final = r_rx_final;

endmodule

[hdl/uubb_ctrl.sv]
// ----------------------------------------------------------------------------
// uubb_ctrl
// Command sequencer: decodes one item, drives ring operations, emits results.
// ----------------------------------------------------------------------------
module uubb_ctrl
    import uubb_pkg::*;
#(
    parameter int PACKET_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic        o_byte_sel_rx,
    output logic        o_byte_sel_tx,
    output logic        o_last,
    output logic        o_tx_active,
    output t_dp_cmd     o_cmd,
    input  t_dp_sts     i_sts
);
    localparam int PW = $clog2(PACKET_BYTES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_RD, S_EMIT, S_WAIT
    } t_state;

    t_state        r_state, n_state;
    logic [PW-1:0] r_left, n_left;
    logic          r_valid, n_valid;
    logic [2:0]    r_kind, n_kind;
    logic          r_last, n_last;
    logic          r_sel_rx, n_sel_rx, r_sel_tx, n_sel_tx;
    logic          r_wp, n_wp, r_zlp, n_zlp, r_flush, n_flush;
    logic          r_nak, n_nak, r_txen, n_txen;
    logic          r_txb, n_txb;             // tx byte pending after nak clear
    logic          r_pkt, n_pkt;             // emitting packet bytes
    t_dp_cmd       cmd;

    // Decode the item and sequence ring reads and result requests.
    always_comb begin
        n_state = r_state; n_left = r_left; n_valid = r_valid; n_kind = r_kind;
        n_last = r_last; n_sel_rx = r_sel_rx; n_sel_tx = r_sel_tx;
        n_wp = r_wp; n_zlp = r_zlp; n_flush = r_flush; n_nak = r_nak;
        n_txen = r_txen; n_txb = r_txb; n_pkt = r_pkt;
        cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                case (i_sts.command)
                    CMD_UART_BYTE: begin
                        cmd.rx_put = 1'b1;
                        n_state = S_WAIT; // re-check count after put
                        n_pkt = 1'b0;
                    end
                    CMD_UART_IDLE: begin
                        if (!i_sts.rx_empty) begin
                            n_flush = 1'b1;
                            if (!r_wp) begin
                                n_state = S_WAIT; n_pkt = 1'b1;
                            end
                        end
                    end
                    CMD_IN_DONE: begin
                        if (r_zlp) begin
                            n_zlp = 1'b0;
                            if (i_sts.ep_free) begin
                                n_valid = 1'b1; n_kind = KIND_ZLP; n_last = 1'b1;
                                n_sel_rx = 1'b0; n_sel_tx = 1'b0; n_state = S_EMIT;
                            end
                        end else begin
                            n_wp = 1'b0;
                            if (!i_sts.rx_empty) begin
                                if (r_flush || i_sts.rx_full_pkt) begin
                                    n_state = S_WAIT; n_pkt = 1'b1;
                                end
                            end else begin
                                n_flush = 1'b0;
                            end
                        end
                    end
                    CMD_OUT_BEGIN: begin
                        if (i_sts.tx_over_nak) begin
                            n_nak = 1'b1; n_valid = 1'b1; n_kind = KIND_NAK_SET;
                            n_last = 1'b1; n_sel_rx = 1'b0; n_sel_tx = 1'b0;
                            n_state = S_EMIT;
                        end
                    end
                    CMD_OUT_BYTE: cmd.tx_put = 1'b1;
                    CMD_OUT_END: begin
                        if (!i_sts.tx_empty) n_txen = 1'b1;
                        if (r_nak && i_sts.tx_under_clr) begin
                            n_nak = 1'b0; n_valid = 1'b1; n_kind = KIND_NAK_CLR;
                            n_last = 1'b1; n_sel_rx = 1'b0; n_sel_tx = 1'b0;
                            n_state = S_EMIT;
                        end
                    end
                    CMD_TX_READY: begin
                        if (i_sts.tx_empty) begin
                            n_txen = 1'b0;
                            if (r_nak) begin
                                n_nak = 1'b0; n_valid = 1'b1; n_kind = KIND_NAK_CLR;
                                n_last = 1'b1; n_sel_rx = 1'b0; n_sel_tx = 1'b0;
                                n_state = S_EMIT;
                            end
                        end else begin
                            cmd.tx_rd = 1'b1; cmd.tx_pop = 1'b1;
                            if (i_sts.tx_one) n_txen = 1'b0;
                            n_txb = 1'b1; n_pkt = 1'b0;
                            n_state = S_RD;
                        end
                    end
                    default: ;
                endcase
            end
            S_WAIT: begin
                // counts are settled; decide packet send
                n_state = S_IDLE;
                if (n_pkt || (!r_wp && i_sts.rx_full_pkt)) begin
                    if (!i_sts.configured) begin
                        cmd.rx_clear = 1'b1;
                    end else if (i_sts.ep_free) begin
                        cmd.rx_snap = 1'b1;
                        n_wp  = 1'b1;
                        n_zlp = r_zlp | i_sts.rx_full_pkt;
                        n_left = i_sts.rx_full_pkt ? PW'(PACKET_BYTES) : PW'(0);
                        n_pkt = 1'b1;
                        n_state = S_RD;
                    end
                end
                n_pkt = (n_state == S_RD);
            end
            S_RD: begin
                if (r_pkt) begin
                    if (i_sts.rx_empty || (r_left == '0 && i_sts.rx_full_pkt) ||
                        (r_left == '0 && 1'b0)) begin
                        n_state = S_IDLE;
                    end else begin
                        cmd.rx_rd = 1'b1; cmd.rx_pop = 1'b1;
                        n_state = S_EMIT;
                    end
                end else begin
                    // tx byte read done; a due nak clear precedes it
                    n_sel_rx = 1'b0;
                    if (r_nak && i_sts.tx_under_clr) begin
                        n_nak = 1'b0; n_valid = 1'b1; n_kind = KIND_NAK_CLR;
                        n_last = 1'b0; n_sel_tx = 1'b0;
                    end else begin
                        n_txb = 1'b0; n_valid = 1'b1; n_kind = KIND_TX_BYTE;
                        n_last = 1'b1; n_sel_tx = 1'b1;
                    end
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_valid) begin
                    // packet byte read just registered
                    n_valid = 1'b1; n_kind = KIND_IN_BYTE; n_sel_rx = 1'b1;
                    n_sel_tx = 1'b0;
                    if (r_left != '0) n_left = r_left - 1'b1;
                    n_last = i_sts.rx_empty || (r_left == PW'(1));
                end else if (i_out_ready) begin
                    n_valid = 1'b0;
                    if (r_pkt && !r_last) begin
                        n_state = S_RD;
                    end else if (!r_pkt && r_txb && r_kind == KIND_NAK_CLR) begin
                        n_txb = 1'b0; n_valid = 1'b1; n_kind = KIND_TX_BYTE;
                        n_last = 1'b1; n_sel_tx = 1'b1;
                    end else begin
                        n_pkt = 1'b0; n_txb = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= 1'b0; r_wp <= 1'b0; r_zlp <= 1'b0;
            r_flush <= 1'b0; r_nak <= 1'b0; r_txen <= 1'b0; r_pkt <= 1'b0;
            r_txb <= 1'b0; r_left <= '0;
            r_kind <= KIND_IN_BYTE; r_last <= 1'b0; r_sel_rx <= 1'b0;
            r_sel_tx <= 1'b0;
        end else begin
            r_state <= n_state; r_valid <= n_valid; r_wp <= n_wp; r_zlp <= n_zlp;
            r_flush <= n_flush; r_nak <= n_nak; r_txen <= n_txen; r_pkt <= n_pkt;
            r_txb <= n_txb; r_left <= n_left;
            r_kind <= n_kind; r_last <= n_last; r_sel_rx <= n_sel_rx;
            r_sel_tx <= n_sel_tx;
        end
    end

    assign o_cmd         = cmd;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_valid;
    assign o_kind        = r_kind;
    assign o_last        = r_last;
    assign o_byte_sel_rx = r_sel_rx;
    assign o_byte_sel_tx = r_sel_tx;
    assign o_tx_active   = r_txen;

endmodule

[hdl/usb_uart_bridge_buffer_top.sv]
// ----------------------------------------------------------------------------
// usb_uart_bridge_buffer_top
// One USB bulk to UART bridge channel with receive and transmit byte rings.
// ----------------------------------------------------------------------------
// Channel   Dir  tdata (low bit up)                 tuser / tlast
// s_axis    in   command[2:0], data_byte[10:3]      tuser[0] bus_configured,
//                                                   tuser[1] endpoint_free
// m_axis    out  result_kind[2:0], result_byte[10:3], tuser[0] tx_active,
//                receive_level[18:11]               tlast last_of_run
//
// One item at a time: items without output finish in the sequencer, and
// packet bytes are emitted one by one, each read through the ring read port.
// Output stalls hold the sequencer; no input is taken until done.
// Reset is synchronous, active low, and empties both rings at once.
// ----------------------------------------------------------------------------
module usb_uart_bridge_buffer_top
    import uubb_pkg::*;
#(
    parameter int RING_DEPTH   = 128,
    parameter int PACKET_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // command, data_byte
    input  logic [1:0]  s_axis_tuser,  // bus_configured, endpoint_free
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // result_kind, result_byte, receive_level
    output logic        m_axis_tuser,  // tx_active
    output logic        m_axis_tlast   // last_of_run
);
    localparam int CW = $clog2(RING_DEPTH + 1);

    t_dp_cmd       dp_cmd;
    t_dp_sts       dp_sts;
    logic [7:0]    rx_q, tx_q, res_byte, level;
    logic [CW-1:0] rx_count, rx_final;
    logic [2:0]    kind;
    logic          sel_rx, sel_tx;

    uubb_datapath #(.RING_DEPTH(RING_DEPTH), .PACKET_BYTES(PACKET_BYTES)) u_dp (
        .i_clk, .i_rst_n,
        .i_command(s_axis_tdata[2:0]), .i_data_byte(s_axis_tdata[10:3]),
        .i_bus_configured(s_axis_tuser[0]), .i_endpoint_free(s_axis_tuser[1]),
        .i_cmd(dp_cmd), .o_sts(dp_sts), .o_rx_q(rx_q), .o_tx_q(tx_q),
        .o_rx_count(rx_count), .o_rx_final(rx_final)
    );

    uubb_ctrl #(.PACKET_BYTES(PACKET_BYTES)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_kind(kind), .o_byte_sel_rx(sel_rx), .o_byte_sel_tx(sel_tx),
        .o_last(m_axis_tlast), .o_tx_active(m_axis_tuser),
        .o_cmd(dp_cmd), .i_sts(dp_sts)
    );

    assign res_byte = sel_rx ? rx_q : (sel_tx ? tx_q : 8'd0);
    // packet bytes report the level the whole packet leaves behind
    assign level    = sel_rx ? rx_final[7:0] : rx_count[7:0];
    assign m_axis_tdata = {5'd0, level, res_byte, kind};

endmodule
